>>> sv/mcds_pkg.sv
// Shared types, constants and codes of the multipart closing delimiter scanner.
package mcds_pkg;

  localparam int MaxBoundary = 56;
  localparam int DelimMax    = MaxBoundary + 6;
  localparam int NumBndRegs  = (MaxBoundary + 7) / 8;

  typedef logic [$clog2(DelimMax+1)-1:0] cnt_t;
  typedef logic [$clog2(DelimMax)-1:0]   ptr_t;
  typedef logic [MaxBoundary-1:0][7:0]   boundary_t;

  localparam logic [7:0] CharCr   = 8'h0D;
  localparam logic [7:0] CharLf   = 8'h0A;
  localparam logic [7:0] CharDash = 8'h2D;

  localparam logic [2:0] RegLength = 3'd7;

  localparam logic [1:0] StScanning  = 2'd0;
  localparam logic [1:0] StComplete  = 2'd1;
  localparam logic [1:0] StMalformed = 2'd2;

  typedef enum logic [1:0] {
    PH_SCAN,
    PH_TRAILER,
    PH_DONE_OK,
    PH_DONE_BAD
  } phase_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
    logic flush;
  } hb_ctrl_t;

  typedef struct packed {
    logic clear;
    logic scan;
  } mt_ctrl_t;

endpackage

>>> sv/mcds_holdback.sv
// Holdback line: circular byte memory with a prefetched oldest entry.
module mcds_holdback
  import mcds_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  hb_ctrl_t   ctrl,
  input  logic [7:0] din,
  output logic [7:0] oldest,
  output cnt_t       held
);

  logic [7:0] mem [DelimMax];
  logic [7:0] rdata;
  ptr_t rd_ptr, wr_ptr, rd_base, wr_base, rd_ptr_next, wr_ptr_next;
  cnt_t held_cnt, held_next;

  function automatic ptr_t wrap_inc(input ptr_t p);
    return (p == ptr_t'(DelimMax - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    rd_base = ctrl.clear ? '0 : rd_ptr;
    wr_base = ctrl.clear ? '0 : wr_ptr;
    held    = ctrl.clear ? '0 : held_cnt;
    if (ctrl.flush) begin
      rd_ptr_next = '0;
      wr_ptr_next = '0;
      held_next   = '0;
    end else begin
      rd_ptr_next = ctrl.pop  ? wrap_inc(rd_base) : rd_base;
      wr_ptr_next = ctrl.push ? wrap_inc(wr_base) : wr_base;
      held_next   = (ctrl.push && !ctrl.pop) ? held + 1'b1 : held;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      held_cnt <= '0;
    end else begin
      rd_ptr   <= rd_ptr_next;
      wr_ptr   <= wr_ptr_next;
      held_cnt <= held_next;
    end
  end

  // The read port always fetches the entry that will be oldest next cycle.
  // A write to that same entry in this cycle is forwarded.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wr_base] <= din;
    end
    if (ctrl.push && (wr_base == rd_ptr_next)) begin
      rdata <= din;
    end else begin
      rdata <= mem[rd_ptr_next];
    end
  end

  assign oldest = rdata;

endmodule

>>> sv/mcds_matcher.sv
// Delimiter assembly and prefix match vector of the running search.
module mcds_matcher
  import mcds_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  boundary_t  bnd,
  input  logic [5:0] bnd_len,
  input  mt_ctrl_t   ctrl,
  input  logic [7:0] din,
  output logic       match,
  output cnt_t       len
);

  logic [DelimMax-1:0][7:0] delim;
  logic [DelimMax-1:0]      eq, mask, pmv, pmv_base, pmv_new;
  cnt_t                     n, len_m1;

  always_comb begin
    if (bnd_len == '0) begin
      n = cnt_t'(1);
    end else if (cnt_t'(bnd_len) > cnt_t'(MaxBoundary)) begin
      n = cnt_t'(MaxBoundary);
    end else begin
      n = cnt_t'(bnd_len);
    end
  end

  assign len    = n + cnt_t'(6);
  assign len_m1 = len - 1'b1;

  assign delim[0] = CharCr;
  assign delim[1] = CharLf;
  assign delim[2] = CharDash;
  assign delim[3] = CharDash;

  // Past the boundary the two closing dashes follow; anything further is masked.
  for (genvar i = 4; i < DelimMax; i++) begin : g_delim
    if (i - 4 < MaxBoundary) begin : g_bnd
      assign delim[i] = (cnt_t'(i - 4) < n) ? bnd[i-4] : CharDash;
    end else begin : g_tail
      assign delim[i] = CharDash;
    end
  end

  for (genvar i = 0; i < DelimMax; i++) begin : g_cmp
    assign eq[i]   = (delim[i] == din);
    assign mask[i] = (cnt_t'(i) < len);
  end

  assign pmv_base = ctrl.clear ? '0 : pmv;
  assign pmv_new  = {pmv_base[DelimMax-2:0], 1'b1} & eq & mask;
  assign match    = pmv_new[len_m1[$bits(ptr_t)-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      pmv <= '0;
    end else if (ctrl.scan) begin
      pmv <= match ? '0 : pmv_new;
    end else if (ctrl.clear) begin
      pmv <= '0;
    end
  end

endmodule

>>> sv/multipart_closing_delimiter_scanner_core.sv
// Top level of the multipart closing delimiter scanner.
//
//   channel  direction  handshake          payload
//   s_*      in         tvalid/tready      tdata body byte, tuser first, tlast last
//   m_*      out        tvalid/tready      tdata file flag/byte/status, tlast finished
//   cfg_*    in         cfg_we (no wait)   register index and 64-bit data
//
// One body byte is taken per cycle unless the output stalls; the whole scan step
// for a byte completes in the cycle it is accepted and its result word sits in
// the output register. The oldest held byte is prefetched from the holdback memory.
// Reset is synchronous and needs no clearing pass. Input is accepted whenever the
// output register is empty or being drained in the same cycle.
module multipart_closing_delimiter_scanner_core
  import mcds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // body_byte
  input  logic        s_tuser,   // first_of_body
  input  logic        s_tlast,   // last_of_body
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // file_valid, file_byte, status, zero pad
  output logic        m_tlast,   // finished
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [NumBndRegs-1:0][63:0] bnd_regs;
  logic [5:0]                  bnd_len;

  phase_t     phase, phase_base, phase_mid, phase_next;
  logic [1:0] tc, tc_base, tc_mid;
  logic       tb, tb_base, tb_mid;

  logic       accept, clear, done_base, ok, match, fvalid, fin;
  logic [1:0] st;
  logic [7:0] oldest;
  cnt_t       held, held_after, len;
  hb_ctrl_t   hb_ctrl;
  mt_ctrl_t   mt_ctrl;

  logic       out_fvalid, out_fin;
  logic [7:0] out_fbyte;
  logic [1:0] out_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      bnd_regs <= '0;
      bnd_len  <= 6'd1;
    end else if (cfg_we) begin
      if (cfg_index == RegLength) begin
        bnd_len <= cfg_data[5:0];
      end else begin
        bnd_regs[cfg_index] <= cfg_data;
      end
    end
  end

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign clear    = accept && s_tuser;

  assign phase_base = clear ? PH_SCAN : phase;
  assign tc_base    = clear ? 2'd0 : tc;
  assign tb_base    = clear ? 1'b0 : tb;
  assign done_base  = (phase_base == PH_DONE_OK) || (phase_base == PH_DONE_BAD);
  assign held_after = held + 1'b1;

  mcds_holdback u_holdback (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (hb_ctrl),
    .din    (s_tdata),
    .oldest (oldest),
    .held   (held)
  );

  mcds_matcher u_matcher (
    .clk     (clk),
    .rst     (rst),
    .bnd     (boundary_t'(bnd_regs)),
    .bnd_len (bnd_len),
    .ctrl    (mt_ctrl),
    .din     (s_tdata),
    .match   (match),
    .len     (len)
  );

  // Next state of the phase and the trailer check.
  always_comb begin
    phase_mid = phase_base;
    tc_mid    = tc_base;
    tb_mid    = tb_base;
    case (phase_base)
      PH_SCAN: begin
        if (match) begin
          phase_mid = PH_TRAILER;
          tc_mid    = 2'd0;
          tb_mid    = 1'b0;
        end
      end
      PH_TRAILER: begin
        case (tc_base)
          2'd0:    tb_mid = tb_base || (s_tdata != CharCr);
          2'd1:    tb_mid = tb_base || (s_tdata != CharLf);
          default: tb_mid = 1'b1;
        endcase
        tc_mid = (tc_base < 2'd2) ? tc_base + 1'b1 : tc_base;
      end
      default: ;
    endcase
    ok = (phase_mid == PH_TRAILER) && !tb_mid && ((tc_mid == 2'd0) || (tc_mid == 2'd2));
    phase_next = phase_mid;
    if (s_tlast && !done_base) begin
      phase_next = ok ? PH_DONE_OK : PH_DONE_BAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SCAN;
      tc    <= 2'd0;
      tb    <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      tc    <= tc_mid;
      tb    <= tb_mid;
    end
  end

  // Outputs of the step: memory and matcher control, result fields.
  always_comb begin
    hb_ctrl.clear = clear;
    hb_ctrl.push  = accept && (phase_base == PH_SCAN);
    hb_ctrl.flush = hb_ctrl.push && match;
    hb_ctrl.pop   = hb_ctrl.push && !match && (held_after >= len);
    mt_ctrl.clear = clear;
    mt_ctrl.scan  = hb_ctrl.push;
    // On a match only the byte in front of the delimiter leaves; the rest is dropped.
    fvalid = hb_ctrl.push && (match ? (held_after > len) : (held_after >= len));
    fin    = done_base || s_tlast;
    if (done_base) begin
      st = (phase_base == PH_DONE_OK) ? StComplete : StMalformed;
    end else if (s_tlast) begin
      st = ok ? StComplete : StMalformed;
    end else begin
      st = ((phase_mid == PH_TRAILER) && tb_mid) ? StMalformed : StScanning;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_fvalid <= fvalid;
      out_fbyte  <= fvalid ? oldest : 8'h00;
      out_fin    <= fin;
      out_st     <= st;
    end
  end

  assign m_tdata = {5'b00000, out_st, out_fbyte, out_fvalid};
  assign m_tlast = out_fin;

  a_held_bound : assert property (@(posedge clk) disable iff (rst)
    held < cnt_t'(DelimMax))
    else $error("holdback count beyond memory depth");

  a_flush_empties : assert property (@(posedge clk) disable iff (rst)
    hb_ctrl.flush |=> (held == '0))
    else $error("holdback not empty after delimiter match");

  a_done_no_data : assert property (@(posedge clk) disable iff (rst)
    (accept && done_base) |=> (m_tvalid && !m_tdata[0] && m_tlast))
    else $error("file byte released after end of body");

  a_release_pops : assert property (@(posedge clk) disable iff (rst)
    fvalid |-> (hb_ctrl.pop || hb_ctrl.flush))
    else $error("file byte released without leaving the holdback");

endmodule
